// ===== hdl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the single-source shortest-path engine.
// ----------------------------------------------------------------------------
package ssp_pkg;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_SOLVE = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_QUERY,
        ST_SEED,
        ST_POP,
        ST_POP_TOP,
        ST_POP_LAST,
        ST_SIFT,
        ST_SIFT_L,
        ST_SIFT_R,
        ST_VISIT,
        ST_VISIT_CHK,
        ST_EDGE,
        ST_EDGE_CHK,
        ST_RELAX,
        ST_UP,
        ST_UP_CMP
    } state_t;

    typedef struct packed {
        logic [31:0] distance;
        logic        reachable;
        status_t     status;
    } res_t;

    localparam int          CFG_W            = 9;
    localparam logic [8:0]  NODE_COUNT_RESET = 9'd256;
    localparam logic [31:0] DIST_SAT         = 32'hFFFF_FFFF;

endpackage

// ===== hdl/ssp_engine.sv =====
// ----------------------------------------------------------------------------
// ssp_engine
// Command sequencer with the edge table, the distance table and the binary
// min-heap, each held in a synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module ssp_engine #(
    parameter int MAX_NODES   = 256,
    parameter int MAX_EDGES   = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [ssp_pkg::CFG_W-1:0] node_count,
    input  logic                    start,
    input  logic [1:0]              cmd,
    input  logic [7:0]              node,
    input  logic [7:0]              edge_head,
    input  logic [15:0]             edge_weight,
    output logic                    busy,
    output logic                    done,
    output ssp_pkg::res_t           result
);

    localparam int NW       = $clog2(MAX_NODES);
    localparam int CW       = ($clog2(MAX_NODES + 1) > ssp_pkg::CFG_W) ?
                              $clog2(MAX_NODES + 1) : ssp_pkg::CFG_W;
    localparam int EA       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW      = $clog2(MAX_EDGES + 1);
    localparam int HEAP_CAP = MAX_EDGES + 1;
    localparam int HA       = $clog2(HEAP_CAP);
    localparam int HW       = $clog2(HEAP_CAP + 1);
    localparam int PW       = HA + 2;
    localparam int EDGE_W   = 2 * NW + WEIGHT_BITS;
    localparam int HEAP_W   = 32 + NW;
    localparam int DW       = 33;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_NODES);

    function automatic logic less(input logic [31:0] ka, input logic [NW-1:0] na,
                                  input logic [31:0] kb, input logic [NW-1:0] nb);
        return (ka < kb) || ((ka == kb) && (na < nb));
    endfunction

    logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
    logic [DW-1:0]     dist_mem [MAX_NODES];
    logic [HEAP_W-1:0] heap_mem [HEAP_CAP];

    logic              edge_we;
    logic [EA-1:0]     edge_waddr;
    logic [EDGE_W-1:0] edge_wdata;
    logic [EA-1:0]     edge_raddr;
    logic [EDGE_W-1:0] edge_rdata_reg;

    logic              dist_we;
    logic [NW-1:0]     dist_waddr;
    logic [DW-1:0]     dist_wdata;
    logic [NW-1:0]     dist_raddr;
    logic [DW-1:0]     dist_rdata_reg;

    logic              heap_we;
    logic [HA-1:0]     heap_waddr;
    logic [HEAP_W-1:0] heap_wdata;
    logic [HA-1:0]     heap_raddr;
    logic [HEAP_W-1:0] heap_rdata_reg;

    ssp_pkg::state_t   state_reg, state_next;
    logic              rstclr_reg, rstclr_next;
    logic [NW-1:0]     idx_reg, idx_next;
    logic [NW-1:0]     src_reg, src_next;
    logic [ETW-1:0]    edge_total_reg, edge_total_next;
    logic [ETW-1:0]    e_reg, e_next;
    logic [HW-1:0]     size_reg, size_next;
    logic [HA-1:0]     hpos_reg, hpos_next;
    logic [31:0]       cur_key_reg, cur_key_next;
    logic [NW-1:0]     cur_node_reg, cur_node_next;
    logic [31:0]       best_key_reg, best_key_next;
    logic [NW-1:0]     best_node_reg, best_node_next;
    logic              best_left_reg, best_left_next;
    logic [31:0]       d_reg, d_next;
    logic [NW-1:0]     u_reg, u_next;
    logic [NW-1:0]     head_reg, head_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic              done_reg, done_next;
    ssp_pkg::res_t     res_reg, res_next;

    logic [CW-1:0]     cnt;
    logic              accept;
    logic              node_ok;
    logic              head_ok;
    ssp_pkg::status_t  add_status;
    logic [PW-1:0]     lpos;
    logic [PW-1:0]     rpos;
    logic              l_in;
    logic              r_in;
    logic [HA-1:0]     parent;
    logic [31:0]       hr_key;
    logic [NW-1:0]     hr_node;
    logic              left_lt;
    logic              right_lt;
    logic              up_lt;
    logic [NW-1:0]     er_tail;
    logic [NW-1:0]     er_head;
    logic              edge_match;
    logic [32:0]       sum;
    logic [31:0]       nd;
    logic              improve;
    logic              visit_ok;

    assign cnt     = (CW'(node_count) > MAX_CNT) ? MAX_CNT : CW'(node_count);
    assign accept  = start && (state_reg == ssp_pkg::ST_IDLE);
    assign node_ok = CW'(node) < cnt;
    assign head_ok = CW'(edge_head) < cnt;
    assign add_status = (!node_ok || !head_ok) ? ssp_pkg::STATUS_RANGE :
                        (edge_total_reg >= ETW'(MAX_EDGES)) ? ssp_pkg::STATUS_FULL :
                        ssp_pkg::STATUS_OK;

    assign lpos   = {1'b0, hpos_reg, 1'b1};
    assign rpos   = lpos + PW'(1);
    assign l_in   = lpos < PW'(size_reg);
    assign r_in   = rpos < PW'(size_reg);
    assign parent = (hpos_reg - HA'(1)) >> 1;

    assign hr_key   = heap_rdata_reg[HEAP_W-1 -: 32];
    assign hr_node  = heap_rdata_reg[NW-1:0];
    assign left_lt  = less(hr_key, hr_node, cur_key_reg, cur_node_reg);
    assign right_lt = less(hr_key, hr_node, best_key_reg, best_node_reg);
    assign up_lt    = less(cur_key_reg, cur_node_reg, hr_key, hr_node);

    assign er_tail    = edge_rdata_reg[EDGE_W-1 -: NW];
    assign er_head    = edge_rdata_reg[WEIGHT_BITS +: NW];
    assign edge_match = (er_tail == u_reg) && (CW'(er_head) < cnt);

    assign sum      = {1'b0, d_reg} + 33'(w_reg);
    assign nd       = sum[32] ? ssp_pkg::DIST_SAT : sum[31:0];
    assign improve  = !dist_rdata_reg[32] || (dist_rdata_reg[31:0] > nd);
    assign visit_ok = dist_rdata_reg[32] && (dist_rdata_reg[31:0] == d_reg);

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_rdata_reg <= edge_mem[edge_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rdata_reg <= dist_mem[dist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rdata_reg <= heap_mem[heap_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd == ssp_pkg::CMD_QUERY) && node_ok)
                    begin
                        state_next = ssp_pkg::ST_QUERY;
                    end
                    else if ((cmd == ssp_pkg::CMD_SOLVE) && node_ok)
                    begin
                        state_next = ssp_pkg::ST_CLEAR;
                    end
                end
            end
            ssp_pkg::ST_QUERY:
            begin
                state_next = ssp_pkg::ST_IDLE;
            end
            ssp_pkg::ST_CLEAR:
            begin
                if (idx_reg == NW'(MAX_NODES - 1))
                begin
                    state_next = rstclr_reg ? ssp_pkg::ST_IDLE : ssp_pkg::ST_SEED;
                end
            end
            ssp_pkg::ST_SEED:
            begin
                state_next = ssp_pkg::ST_POP;
            end
            ssp_pkg::ST_POP:
            begin
                state_next = (size_reg == '0) ? ssp_pkg::ST_IDLE : ssp_pkg::ST_POP_TOP;
            end
            ssp_pkg::ST_POP_TOP:
            begin
                state_next = (size_reg == HW'(1)) ? ssp_pkg::ST_VISIT : ssp_pkg::ST_POP_LAST;
            end
            ssp_pkg::ST_POP_LAST:
            begin
                state_next = ssp_pkg::ST_SIFT;
            end
            ssp_pkg::ST_SIFT:
            begin
                state_next = l_in ? ssp_pkg::ST_SIFT_L : ssp_pkg::ST_VISIT;
            end
            ssp_pkg::ST_SIFT_L:
            begin
                if (r_in)
                begin
                    state_next = ssp_pkg::ST_SIFT_R;
                end
                else
                begin
                    state_next = left_lt ? ssp_pkg::ST_SIFT : ssp_pkg::ST_VISIT;
                end
            end
            ssp_pkg::ST_SIFT_R:
            begin
                state_next = (right_lt || best_left_reg) ? ssp_pkg::ST_SIFT :
                             ssp_pkg::ST_VISIT;
            end
            ssp_pkg::ST_VISIT:
            begin
                state_next = (CW'(u_reg) >= cnt) ? ssp_pkg::ST_POP : ssp_pkg::ST_VISIT_CHK;
            end
            ssp_pkg::ST_VISIT_CHK:
            begin
                state_next = visit_ok ? ssp_pkg::ST_EDGE : ssp_pkg::ST_POP;
            end
            ssp_pkg::ST_EDGE:
            begin
                state_next = (e_reg >= edge_total_reg) ? ssp_pkg::ST_POP :
                             ssp_pkg::ST_EDGE_CHK;
            end
            ssp_pkg::ST_EDGE_CHK:
            begin
                state_next = edge_match ? ssp_pkg::ST_RELAX : ssp_pkg::ST_EDGE;
            end
            ssp_pkg::ST_RELAX:
            begin
                state_next = (improve && (size_reg < HW'(HEAP_CAP))) ? ssp_pkg::ST_UP :
                             ssp_pkg::ST_EDGE;
            end
            ssp_pkg::ST_UP:
            begin
                state_next = (hpos_reg == '0) ? ssp_pkg::ST_EDGE : ssp_pkg::ST_UP_CMP;
            end
            ssp_pkg::ST_UP_CMP:
            begin
                state_next = up_lt ? ssp_pkg::ST_UP : ssp_pkg::ST_EDGE;
            end
            default:
            begin
                state_next = ssp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rstclr_next     = rstclr_reg;
        idx_next        = idx_reg;
        src_next        = src_reg;
        edge_total_next = edge_total_reg;
        e_next          = e_reg;
        size_next       = size_reg;
        hpos_next       = hpos_reg;
        cur_key_next    = cur_key_reg;
        cur_node_next   = cur_node_reg;
        best_key_next   = best_key_reg;
        best_node_next  = best_node_reg;
        best_left_next  = best_left_reg;
        d_next          = d_reg;
        u_next          = u_reg;
        head_next       = head_reg;
        w_next          = w_reg;
        done_next       = 1'b0;
        res_next        = res_reg;

        edge_we    = 1'b0;
        edge_waddr = EA'(edge_total_reg);
        edge_wdata = {NW'(node), NW'(edge_head), WEIGHT_BITS'(edge_weight)};
        edge_raddr = EA'(e_reg);

        dist_we    = 1'b0;
        dist_waddr = idx_reg;
        dist_wdata = '0;
        dist_raddr = NW'(node);

        heap_we    = 1'b0;
        heap_waddr = hpos_reg;
        heap_wdata = {cur_key_reg, cur_node_reg};
        heap_raddr = '0;

        unique case (state_reg)
            ssp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_next = '{distance: 32'd0, reachable: 1'b0,
                                 status: ssp_pkg::STATUS_OK};
                    unique case (cmd)
                        ssp_pkg::CMD_ADD:
                        begin
                            done_next       = 1'b1;
                            res_next.status = add_status;
                            if (add_status == ssp_pkg::STATUS_OK)
                            begin
                                edge_we         = 1'b1;
                                edge_total_next = edge_total_reg + ETW'(1);
                            end
                        end
                        ssp_pkg::CMD_SOLVE:
                        begin
                            if (node_ok)
                            begin
                                src_next    = NW'(node);
                                idx_next    = '0;
                                rstclr_next = 1'b0;
                            end
                            else
                            begin
                                done_next       = 1'b1;
                                res_next.status = ssp_pkg::STATUS_RANGE;
                            end
                        end
                        ssp_pkg::CMD_QUERY:
                        begin
                            if (!node_ok)
                            begin
                                done_next       = 1'b1;
                                res_next.status = ssp_pkg::STATUS_RANGE;
                            end
                        end
                        ssp_pkg::CMD_CLEAR:
                        begin
                            done_next       = 1'b1;
                            edge_total_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ssp_pkg::ST_QUERY:
            begin
                done_next          = 1'b1;
                res_next.reachable = dist_rdata_reg[32];
                res_next.distance  = dist_rdata_reg[32] ? dist_rdata_reg[31:0] : 32'd0;
            end
            ssp_pkg::ST_CLEAR:
            begin
                dist_we  = 1'b1;
                idx_next = idx_reg + NW'(1);
            end
            ssp_pkg::ST_SEED:
            begin
                dist_we    = 1'b1;
                dist_waddr = src_reg;
                dist_wdata = {1'b1, 32'd0};
                heap_we    = 1'b1;
                heap_waddr = '0;
                heap_wdata = {32'd0, src_reg};
                size_next  = HW'(1);
            end
            ssp_pkg::ST_POP:
            begin
                heap_raddr = '0;
                if (size_reg == '0)
                begin
                    done_next = 1'b1;
                end
            end
            ssp_pkg::ST_POP_TOP:
            begin
                d_next     = hr_key;
                u_next     = hr_node;
                size_next  = size_reg - HW'(1);
                heap_raddr = HA'(size_reg - HW'(1));
            end
            ssp_pkg::ST_POP_LAST:
            begin
                cur_key_next  = hr_key;
                cur_node_next = hr_node;
                hpos_next     = '0;
            end
            ssp_pkg::ST_SIFT:
            begin
                heap_raddr = HA'(lpos);
                if (!l_in)
                begin
                    heap_we = 1'b1;
                end
            end
            ssp_pkg::ST_SIFT_L:
            begin
                best_left_next = left_lt;
                best_key_next  = left_lt ? hr_key : cur_key_reg;
                best_node_next = left_lt ? hr_node : cur_node_reg;
                heap_raddr     = HA'(rpos);
                if (!r_in)
                begin
                    heap_we = 1'b1;
                    if (left_lt)
                    begin
                        heap_wdata = heap_rdata_reg;
                        hpos_next  = HA'(lpos);
                    end
                end
            end
            ssp_pkg::ST_SIFT_R:
            begin
                heap_we = 1'b1;
                if (right_lt)
                begin
                    heap_wdata = heap_rdata_reg;
                    hpos_next  = HA'(rpos);
                end
                else if (best_left_reg)
                begin
                    heap_wdata = {best_key_reg, best_node_reg};
                    hpos_next  = HA'(lpos);
                end
            end
            ssp_pkg::ST_VISIT:
            begin
                dist_raddr = u_reg;
            end
            ssp_pkg::ST_VISIT_CHK:
            begin
                e_next = '0;
            end
            ssp_pkg::ST_EDGE:
            begin
                edge_raddr = EA'(e_reg);
            end
            ssp_pkg::ST_EDGE_CHK:
            begin
                e_next     = e_reg + ETW'(1);
                head_next  = er_head;
                w_next     = edge_rdata_reg[WEIGHT_BITS-1:0];
                dist_raddr = er_head;
            end
            ssp_pkg::ST_RELAX:
            begin
                if (improve)
                begin
                    dist_we    = 1'b1;
                    dist_waddr = head_reg;
                    dist_wdata = {1'b1, nd};
                    if (size_reg < HW'(HEAP_CAP))
                    begin
                        cur_key_next  = nd;
                        cur_node_next = head_reg;
                        hpos_next     = HA'(size_reg);
                        size_next     = size_reg + HW'(1);
                    end
                end
            end
            ssp_pkg::ST_UP:
            begin
                heap_raddr = parent;
                if (hpos_reg == '0)
                begin
                    heap_we = 1'b1;
                end
            end
            ssp_pkg::ST_UP_CMP:
            begin
                heap_we = 1'b1;
                if (up_lt)
                begin
                    heap_wdata = heap_rdata_reg;
                    hpos_next  = parent;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ssp_pkg::ST_CLEAR;
            rstclr_reg     <= 1'b1;
            idx_reg        <= '0;
            edge_total_reg <= '0;
            e_reg          <= '0;
            size_reg       <= '0;
            hpos_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rstclr_reg     <= rstclr_next;
            idx_reg        <= idx_next;
            edge_total_reg <= edge_total_next;
            e_reg          <= e_next;
            size_reg       <= size_next;
            hpos_reg       <= hpos_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        cur_key_reg   <= cur_key_next;
        cur_node_reg  <= cur_node_next;
        best_key_reg  <= best_key_next;
        best_node_reg <= best_node_next;
        best_left_reg <= best_left_next;
        d_reg         <= d_next;
        u_reg         <= u_next;
        head_reg      <= head_next;
        w_reg         <= w_next;
        res_reg       <= res_next;
    end

    assign busy   = (state_reg != ssp_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== hdl/single_source_shortest_path_top.sv =====
// ----------------------------------------------------------------------------
// single_source_shortest_path_top
// Dijkstra shortest-path engine with an APB register port for the node count.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. Its result
// appears for exactly one cycle with done high and cannot be held off. Add edge
// and clear edges report in the next cycle and busy stays low, so they may
// follow each other every cycle; a query reports once the query state has read
// the distance table. A solve first clears the distance table at one entry per
// cycle, then pops the heap in key order and, for each settled node, scans
// every stored edge and pushes each improved distance into the heap. The heap,
// edge and distance memories each have one read port. After reset, busy stays
// high while the distance table clears.
module single_source_shortest_path_top #(
    parameter int MAX_NODES   = 256,
    parameter int MAX_EDGES   = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [1:0]  cmd,
    input  logic [7:0]  node,
    input  logic [7:0]  edge_head,
    input  logic [15:0] edge_weight,
    output logic [31:0] distance,
    output logic        reachable,
    output logic [1:0]  status
);

    logic [ssp_pkg::CFG_W-1:0] node_count_reg, node_count_next;
    logic                      cfg_write;
    ssp_pkg::res_t             result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);

    always_comb
    begin
        node_count_next = node_count_reg;
        if (cfg_write)
        begin
            node_count_next = pwdata[ssp_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= ssp_pkg::NODE_COUNT_RESET;
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {23'd0, node_count_reg} : 32'd0;

    ssp_engine #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .node_count  (node_count_reg),
        .start       (start),
        .cmd         (cmd),
        .node        (node),
        .edge_head   (edge_head),
        .edge_weight (edge_weight),
        .busy        (busy),
        .done        (done),
        .result      (result)
    );

    assign distance  = result.distance;
    assign reachable = result.reachable;
    assign status    = result.status;

endmodule

// ===== dv/tb_single_source_shortest_path_top.sv =====
// ----------------------------------------------------------------------------
// tb_single_source_shortest_path_top
// Self-checking testbench for the single-source shortest-path engine.
// ----------------------------------------------------------------------------
// Edge, solve, query and clear transactions go to the block through its
// start/busy handshake with random gaps. Between phases the node count is
// reprogrammed through the APB port. A scoreboard keeps its own edge table and
// distance table and predicts each result, which is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_single_source_shortest_path_top;

    class dist_scoreboard;
        bit [8:0]      node_cnt_reg;
        bit [7:0]      tail_tbl[1024];
        bit [7:0]      head_tbl[1024];
        bit [15:0]     weight_tbl[1024];
        int unsigned   stored_edges;
        bit            reached[256];
        bit [31:0]     shortest[256];
        ssp_pkg::res_t pending_results[$];
        int unsigned   mismatches;
        int unsigned   results_seen;

        function new();
            node_cnt_reg = ssp_pkg::NODE_COUNT_RESET;
            stored_edges = 0;
            mismatches   = 0;
            results_seen = 0;
            foreach (reached[i])
            begin
                reached[i]  = 1'b0;
                shortest[i] = '0;
            end
        endfunction

        function int unsigned eff_count();
            return (node_cnt_reg > 256) ? 256 : node_cnt_reg;
        endfunction

        function void relax_from(int unsigned src, int unsigned cnt);
            bit          settled[256];
            int          u;
            bit [32:0]   sum;
            bit [31:0]   nd;
            foreach (reached[i])
            begin
                reached[i]  = 1'b0;
                shortest[i] = '0;
                settled[i]  = 1'b0;
            end
            reached[src] = 1'b1;
            forever
            begin
                u = -1;
                for (int i = 0; i < 256; i++)
                    if (reached[i] && !settled[i] && (u < 0 || shortest[i] < shortest[u]))
                        u = i;
                if (u < 0)
                    break;
                settled[u] = 1'b1;
                for (int e = 0; e < stored_edges; e++)
                begin
                    if (tail_tbl[e] != u || head_tbl[e] >= cnt)
                        continue;
                    sum = {1'b0, shortest[u]} + weight_tbl[e];
                    nd  = sum[32] ? ssp_pkg::DIST_SAT : sum[31:0];
                    if (!reached[head_tbl[e]] || shortest[head_tbl[e]] > nd)
                    begin
                        reached[head_tbl[e]]  = 1'b1;
                        shortest[head_tbl[e]] = nd;
                    end
                end
            end
        endfunction

        function void note_input(ssp_pkg::cmd_t c, bit [7:0] n, bit [7:0] h, bit [15:0] w);
            ssp_pkg::res_t r;
            int unsigned   cnt;
            cnt = eff_count();
            r.distance  = '0;
            r.reachable = 1'b0;
            r.status    = ssp_pkg::STATUS_OK;
            case (c)
                ssp_pkg::CMD_ADD:
                begin
                    if (n >= cnt || h >= cnt)
                        r.status = ssp_pkg::STATUS_RANGE;
                    else if (stored_edges >= 1024)
                        r.status = ssp_pkg::STATUS_FULL;
                    else
                    begin
                        tail_tbl[stored_edges]   = n;
                        head_tbl[stored_edges]   = h;
                        weight_tbl[stored_edges] = w;
                        stored_edges++;
                    end
                end
                ssp_pkg::CMD_SOLVE:
                begin
                    if (n >= cnt)
                        r.status = ssp_pkg::STATUS_RANGE;
                    else
                        relax_from(n, cnt);
                end
                ssp_pkg::CMD_QUERY:
                begin
                    if (n >= cnt)
                        r.status = ssp_pkg::STATUS_RANGE;
                    else if (reached[n])
                    begin
                        r.reachable = 1'b1;
                        r.distance  = shortest[n];
                    end
                end
                default:
                    stored_edges = 0;
            endcase
            pending_results = {pending_results, r};
        endfunction

        function void check_result(bit [31:0] d, bit r, bit [1:0] s);
            ssp_pkg::res_t exp_r;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing expected: dist=%0d reach=%0b st=%0d",
                             d, r, s);
                return;
            end
            exp_r = pending_results.pop_front();
            if (exp_r.distance !== d || exp_r.reachable !== r || exp_r.status !== s)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp dist=%0d reach=%0b st=%0d, got dist=%0d reach=%0b st=%0d",
                             exp_r.distance, exp_r.reachable, exp_r.status, d, r, s);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        done;
    logic [1:0]  cmd;
    logic [7:0]  node;
    logic [7:0]  edge_head;
    logic [15:0] edge_weight;
    logic [31:0] distance;
    logic        reachable;
    logic [1:0]  status;

    dist_scoreboard sb;
    int unsigned    items_sent;
    int unsigned    solves_sent;
    bit             gaps_on;

    single_source_shortest_path_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .cmd         (cmd),
        .node        (node),
        .edge_head   (edge_head),
        .edge_weight (edge_weight),
        .distance    (distance),
        .reachable   (reachable),
        .status      (status)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(distance, reachable, status);
    end

    task automatic send_item(ssp_pkg::cmd_t c, bit [7:0] n, bit [7:0] h, bit [15:0] w);
        start       <= 1'b1;
        cmd         <= c;
        node        <= n;
        edge_head   <= h;
        edge_weight <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_input(c, n, h, w);
        items_sent++;
        if (c == ssp_pkg::CMD_SOLVE)
            solves_sent++;
    endtask

    task automatic idle_gap();
        int unsigned len;
        int unsigned roll;
        roll = $urandom_range(99);
        if (!gaps_on || roll < 60)
            len = 0;
        else if (roll < 94)
            len = $urandom_range(3, 1);
        else
            len = $urandom_range(40, 10);
        if (len > 0)
        begin
            start <= 1'b0;
            repeat (len)
                @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_node_count(bit [8:0] v);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= {23'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.node_cnt_reg = v;
        @(posedge clk);
    endtask

    function automatic bit [7:0] pick_node(int unsigned cnt);
        if (cnt == 0 || $urandom_range(99) < 8)
            return 8'($urandom);
        return 8'($urandom_range(cnt - 1));
    endfunction

    function automatic bit [15:0] pick_weight();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(20));
        endcase
    endfunction

    task automatic random_phase(bit [8:0] cnt_val, int unsigned n_items);
        int unsigned cnt;
        int unsigned roll;
        write_node_count(cnt_val);
        cnt     = sb.eff_count();
        gaps_on = ($urandom_range(3) != 0);
        send_item(ssp_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom));
        for (int i = 0; i < n_items; i++)
        begin
            idle_gap();
            roll = $urandom_range(99);
            if (roll < 50)
                send_item(ssp_pkg::CMD_ADD, pick_node(cnt), pick_node(cnt), pick_weight());
            else if (roll < 62)
                send_item(ssp_pkg::CMD_SOLVE, pick_node(cnt), 8'($urandom), 16'($urandom));
            else if (roll < 97)
                send_item(ssp_pkg::CMD_QUERY, pick_node(cnt), 8'($urandom), 16'($urandom));
            else
                send_item(ssp_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("single_source_shortest_path_top: mismatch");
        $finish;
    end

    initial
    begin
        bit [8:0] cnt_choices[9];
        cnt_choices = '{9'd1, 9'd2, 9'd3, 9'd8, 9'd16, 9'd40, 9'd256, 9'd300, 9'd511};
        sb          = new();
        items_sent  = 0;
        solves_sent = 0;
        gaps_on     = 1'b1;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        start       = 1'b0;
        cmd         = ssp_pkg::CMD_ADD;
        node        = '0;
        edge_head   = '0;
        edge_weight = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes at full node count, then clear keeps old distances.
        send_item(ssp_pkg::CMD_ADD, 8'd0, 8'd255, 16'hFFFF);
        send_item(ssp_pkg::CMD_ADD, 8'd255, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_ADD, 8'd255, 8'd170, 16'h5555);
        send_item(ssp_pkg::CMD_SOLVE, 8'd0, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_QUERY, 8'd255, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_QUERY, 8'd170, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_QUERY, 8'd0, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_QUERY, 8'd7, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_CLEAR, 8'd0, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_QUERY, 8'd255, 8'd0, 16'd0);

        // Out-of-range nodes for add, solve and query.
        write_node_count(9'd4);
        send_item(ssp_pkg::CMD_ADD, 8'd5, 8'd1, 16'd3);
        send_item(ssp_pkg::CMD_ADD, 8'd1, 8'd9, 16'd3);
        send_item(ssp_pkg::CMD_SOLVE, 8'd7, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_QUERY, 8'd200, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_QUERY, 8'd255, 8'd0, 16'd0);

        // Zero node count: every node is out of range.
        write_node_count(9'd0);
        send_item(ssp_pkg::CMD_ADD, 8'd0, 8'd0, 16'd1);
        send_item(ssp_pkg::CMD_SOLVE, 8'd0, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_QUERY, 8'd0, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_CLEAR, 8'd0, 8'd0, 16'd0);

        // Node count shrinks after the edges are loaded.
        write_node_count(9'd16);
        send_item(ssp_pkg::CMD_ADD, 8'd0, 8'd12, 16'd1);
        send_item(ssp_pkg::CMD_ADD, 8'd12, 8'd3, 16'd1);
        send_item(ssp_pkg::CMD_ADD, 8'd0, 8'd3, 16'd50);
        send_item(ssp_pkg::CMD_ADD, 8'd3, 8'd15, 16'd2);
        write_node_count(9'd8);
        send_item(ssp_pkg::CMD_SOLVE, 8'd0, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_QUERY, 8'd3, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_QUERY, 8'd12, 8'd0, 16'd0);

        // Many parallel edges between two nodes.
        write_node_count(9'd2);
        send_item(ssp_pkg::CMD_CLEAR, 8'd0, 8'd0, 16'd0);
        for (int i = 0; i < 12; i++)
        begin
            idle_gap();
            send_item(ssp_pkg::CMD_ADD, 8'($urandom_range(1)), 8'($urandom_range(1)),
                      pick_weight());
        end
        send_item(ssp_pkg::CMD_SOLVE, 8'd0, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_QUERY, 8'd1, 8'd0, 16'd0);
        send_item(ssp_pkg::CMD_CLEAR, 8'd0, 8'd0, 16'd0);

        foreach (cnt_choices[i])
            random_phase(cnt_choices[i], 24);
        random_phase(9'd511, 10);
        random_phase(9'd1, 10);

        drain();
        repeat (20)
            @(posedge clk);
        $display("Ran %0d transactions including %0d solves over node counts 0 to 511.",
                 items_sent, solves_sent);
        $display("Checked %0d results, %0d mismatches.", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("single_source_shortest_path_top: match");
        else
            $display("single_source_shortest_path_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ssp_pkg.sv
hdl/ssp_engine.sv
hdl/single_source_shortest_path_top.sv
dv/tb_single_source_shortest_path_top.sv
